/* hdl/bve_pkg.sv */
`default_nettype none

package bve_pkg;

    localparam int NUM_VECTORS_DEF = 4;
    localparam int VECTOR_BITS_DEF = 256;
    localparam int WORD_BITS_DEF   = 64;

    localparam int WIDX_W = 9;
    localparam int VIDX_W = 4;

    localparam logic [4:0] CMD_CLEAR  = 5'd0;
    localparam logic [4:0] CMD_SET    = 5'd1;
    localparam logic [4:0] CMD_UNSET  = 5'd2;
    localparam logic [4:0] CMD_TOGGLE = 5'd3;
    localparam logic [4:0] CMD_TEST   = 5'd4;
    localparam logic [4:0] CMD_COUNT  = 5'd5;
    localparam logic [4:0] CMD_EMPTY  = 5'd6;
    localparam logic [4:0] CMD_FULL   = 5'd7;
    localparam logic [4:0] CMD_EQUAL  = 5'd8;
    localparam logic [4:0] CMD_NOT    = 5'd9;
    localparam logic [4:0] CMD_OR     = 5'd10;
    localparam logic [4:0] CMD_XOR    = 5'd11;
    localparam logic [4:0] CMD_AND    = 5'd12;
    localparam logic [4:0] CMD_DIFF   = 5'd13;
    localparam logic [4:0] CMD_LSHIFT = 5'd14;
    localparam logic [4:0] CMD_RSHIFT = 5'd15;
    localparam logic [4:0] CMD_COPY   = 5'd16;

    localparam logic [1:0] WR_ZERO = 2'd0;
    localparam logic [1:0] WR_BUF  = 2'd1;
    localparam logic [1:0] WR_BIT  = 2'd2;
    localparam logic [1:0] WR_MASK = 2'd3;

    localparam logic [1:0] VS_A  = 2'd0;
    localparam logic [1:0] VS_D  = 2'd1;
    localparam logic [1:0] VS_SW = 2'd2;
    localparam logic [1:0] VS_RD = 2'd3;

    typedef struct packed {
        logic [4:0] cmd;
        logic [7:0] bit_index;
        logic [1:0] src_a;
        logic [1:0] src_b;
        logic [1:0] dest;
        logic [8:0] shift_count;
    } t_req;

    typedef struct packed {
        logic       flag;
        logic [8:0] pop_count;
        logic       status;
    } t_rsp;

    typedef struct packed {
        logic              ld;
        logic              rd_en;
        logic              rd_sw;
        logic [WIDX_W-1:0] word;
        logic [VIDX_W-1:0] sw_vec;
        logic              acc_en;
        logic              sh_en;
        logic              bit_en;
        logic              wr_en;
        logic [1:0]        wr_src;
        logic [1:0]        wr_vsel;
        logic              out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic              idx_bad;
        logic [WIDX_W-1:0] bit_word;
    } t_dp_stat;

endpackage

`default_nettype wire

/* hdl/bit_vector_engine.sv */
// channel | direction | handshake                 | payload
// req     | in        | i_req_valid / o_req_ready | i_req (t_req)
// rsp     | out       | o_rsp_valid / i_rsp_ready | o_rsp (t_rsp)
// cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (size_in_bits)
//
// Vector commands step word by word. Clear writes each word; count, empty, full and equal
// read each word; other writing commands read each word, then write each back, with a shift
// step between for shifts. Bit commands read one word and, but for test, write it back; an
// out-of-range bit index or unknown command responds without memory access. After reset a
// clearing pass over all vectors runs before requests are taken. A size write in idle starts a
// masking pass. A stalled response stays valid; the engine waits only when its next response is ready.
`default_nettype none

module bit_vector_engine
    import bve_pkg::*;
#(
    parameter int NUM_VECTORS = NUM_VECTORS_DEF,
    parameter int VECTOR_BITS = VECTOR_BITS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_req_valid,
    output logic       o_req_ready,
    input  t_req       i_req,
    output logic       o_rsp_valid,
    input  wire        i_rsp_ready,
    output t_rsp       o_rsp,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire  [8:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    bve_ctrl #(
        .NUM_VECTORS (NUM_VECTORS),
        .VECTOR_BITS (VECTOR_BITS),
        .WORD_BITS   (WORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_cmd       (i_req.cmd),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    bve_dpath #(
        .NUM_VECTORS (NUM_VECTORS),
        .VECTOR_BITS (VECTOR_BITS),
        .WORD_BITS   (WORD_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_rsp      (o_rsp)
    );

endmodule

`default_nettype wire

/* hdl/bve_ctrl.sv */
`default_nettype none

module bve_ctrl
    import bve_pkg::*;
#(
    parameter int NUM_VECTORS = NUM_VECTORS_DEF,
    parameter int VECTOR_BITS = VECTOR_BITS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_req_valid,
    output logic       o_req_ready,
    input  wire  [4:0] i_cmd,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    output logic       o_rsp_valid,
    input  wire        i_rsp_ready,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    localparam int NWORDS = (VECTOR_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int VW     = $clog2(NUM_VECTORS);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_BITRD  = 4'd3;
    localparam logic [3:0] S_BITWR  = 4'd4;
    localparam logic [3:0] S_READ   = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_SHIFT  = 4'd7;
    localparam logic [3:0] S_WRITE  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;
    localparam logic [3:0] S_MSWEEP = 4'd10;
    localparam logic [3:0] S_MDRAIN = 4'd11;

    logic [3:0]     r_state, n_state;
    logic [WIW-1:0] r_w, n_w;
    logic [VW-1:0]  r_v, n_v;
    logic [4:0]     r_cmd, n_cmd;
    logic           r_rd_pend;
    logic           r_out_valid, n_out_valid;
    logic           w_last, v_last, cmd_bit;

    assign w_last  = (r_w == WIW'(NWORDS - 1));
    assign v_last  = (r_v == VW'(NUM_VECTORS - 1));
    assign cmd_bit = (r_cmd == CMD_SET) || (r_cmd == CMD_UNSET) ||
                     (r_cmd == CMD_TOGGLE) || (r_cmd == CMD_TEST);

    assign o_req_ready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_INIT) || (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_w         = r_w;
        n_v         = r_v;
        n_cmd       = r_cmd;
        n_out_valid = (r_out_valid && !i_rsp_ready);
        o_cmd         = '0;
        o_cmd.word    = WIDX_W'(r_w);
        o_cmd.sw_vec  = VIDX_W'(r_v);
        o_cmd.wr_src  = WR_ZERO;
        o_cmd.wr_vsel = VS_SW;
        unique case (r_state)
            S_INIT: begin
                o_cmd.wr_en = 1'b1;
                n_w = w_last ? '0 : r_w + 1'b1;
                if (w_last) begin
                    n_v = v_last ? '0 : r_v + 1'b1;
                    if (v_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                n_w = '0;
                n_v = '0;
                if (i_cfg_valid) begin
                    n_state = S_MSWEEP;
                end else if (i_req_valid) begin
                    o_cmd.ld = 1'b1;
                    n_cmd    = i_cmd;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (cmd_bit) begin
                    n_state = i_stat.idx_bad ? S_DONE : S_BITRD;
                end else if (r_cmd == CMD_CLEAR) begin
                    n_state = S_WRITE;
                end else if (r_cmd >= CMD_COUNT && r_cmd <= CMD_COPY) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BITRD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.word  = i_stat.bit_word;
                n_state     = S_BITWR;
            end
            S_BITWR: begin
                o_cmd.bit_en  = 1'b1;
                o_cmd.wr_en   = (r_cmd != CMD_TEST);
                o_cmd.wr_src  = WR_BIT;
                o_cmd.wr_vsel = VS_RD;
                n_state       = S_DONE;
            end
            S_READ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.acc_en = r_rd_pend;
                n_w = w_last ? '0 : r_w + 1'b1;
                if (w_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.acc_en = 1'b1;
                if (r_cmd <= CMD_EQUAL) begin
                    n_state = S_DONE;
                end else if (r_cmd == CMD_LSHIFT || r_cmd == CMD_RSHIFT) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_SHIFT: begin
                o_cmd.sh_en = 1'b1;
                n_state     = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_src  = (r_cmd == CMD_CLEAR) ? WR_ZERO : WR_BUF;
                o_cmd.wr_vsel = (r_cmd == CMD_CLEAR) ? VS_A : VS_D;
                n_w = w_last ? '0 : r_w + 1'b1;
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.out_ld = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_MSWEEP: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sw   = 1'b1;
                o_cmd.wr_en   = r_rd_pend;
                o_cmd.wr_src  = WR_MASK;
                o_cmd.wr_vsel = VS_RD;
                n_w = w_last ? '0 : r_w + 1'b1;
                if (w_last) begin
                    n_v = v_last ? '0 : r_v + 1'b1;
                    if (v_last) begin
                        n_state = S_MDRAIN;
                    end
                end
            end
            S_MDRAIN: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_src  = WR_MASK;
                o_cmd.wr_vsel = VS_RD;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_w         <= '0;
            r_v         <= '0;
            r_cmd       <= CMD_CLEAR;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_w         <= n_w;
            r_v         <= n_v;
            r_cmd       <= n_cmd;
            r_rd_pend   <= o_cmd.rd_en;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* hdl/bve_dpath.sv */
`default_nettype none

module bve_dpath
    import bve_pkg::*;
#(
    parameter int NUM_VECTORS = NUM_VECTORS_DEF,
    parameter int VECTOR_BITS = VECTOR_BITS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_req       i_req,
    input  wire        i_cfg_we,
    input  wire  [8:0] i_cfg_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    output t_rsp       o_rsp
);

    localparam int NWORDS = (VECTOR_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int VW     = $clog2(NUM_VECTORS);
    localparam int DEPTH  = NUM_VECTORS * NWORDS;
    localparam int AW     = $clog2(DEPTH);
    localparam int BPW    = $clog2(WORD_BITS);
    localparam int VBP    = NWORDS * WORD_BITS;
    localparam int PCW    = $clog2(VBP + 1);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_a, r_rd_b;
    logic [AW-1:0]        r_rd_addr;
    logic [WIW-1:0]       r_rd_w;
    logic [VBP-1:0]       r_buf;
    t_req                 r_req;
    logic [8:0]           r_size;
    logic [PCW-1:0]       r_pc;
    logic                 r_all, r_flag;
    t_rsp                 r_rsp;

    logic [8:0]           eff;
    logic [VW-1:0]        va, vb, vd;
    logic [WIW-1:0]       bw, wword;
    logic [BPW-1:0]       bpos;
    logic [AW-1:0]        addr_a, addr_b, wr_addr;
    logic [WORD_BITS-1:0] wr_data, op_word, bit_sel;
    logic                 cmd_bit;

    function automatic logic [WORD_BITS-1:0] used_mask(input logic [WIW-1:0] w,
                                                       input logic [8:0] e);
        int lo;
        int ei;
        lo = int'(w) * WORD_BITS;
        ei = int'(e);
        if (ei >= lo + WORD_BITS) begin
            used_mask = '1;
        end else if (ei <= lo) begin
            used_mask = '0;
        end else begin
            used_mask = {WORD_BITS{1'b1}} >> (WORD_BITS - (ei - lo));
        end
    endfunction

    function automatic logic [VW-1:0] vmod(input logic [1:0] s);
        if (int'(s) >= NUM_VECTORS) begin
            vmod = VW'(int'(s) - NUM_VECTORS);
        end else begin
            vmod = VW'(s);
        end
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [VW-1:0] v,
                                              input logic [WIW-1:0] w);
        addr_of = AW'(int'(v) * NWORDS + int'(w));
    endfunction

    always_comb begin
        eff = (r_size == 9'd0) ? 9'd1 : r_size;
        if (int'(eff) > VECTOR_BITS) begin
            eff = 9'(VECTOR_BITS);
        end
    end

    assign va      = vmod(r_req.src_a);
    assign vb      = vmod(r_req.src_b);
    assign vd      = vmod(r_req.dest);
    assign wword   = i_cmd.word[WIW-1:0];
    assign cmd_bit = (r_req.cmd == CMD_SET) || (r_req.cmd == CMD_UNSET) ||
                     (r_req.cmd == CMD_TOGGLE) || (r_req.cmd == CMD_TEST);

    always_comb begin
        bw = '0;
        for (int k = 0; k < NWORDS; k++) begin
            if (int'(r_req.bit_index) >= k * WORD_BITS) begin
                bw = WIW'(k);
            end
        end
    end

    assign bpos    = BPW'(int'(r_req.bit_index) - int'(bw) * WORD_BITS);
    assign bit_sel = WORD_BITS'(1) << bpos;

    assign o_stat.idx_bad  = ({1'b0, r_req.bit_index} >= eff);
    assign o_stat.bit_word = WIDX_W'(bw);

    assign addr_a = addr_of(i_cmd.rd_sw ? i_cmd.sw_vec[VW-1:0] : va, wword);
    assign addr_b = addr_of(vb, wword);

    always_comb begin
        case (i_cmd.wr_vsel)
            VS_A:    wr_addr = addr_of(va, wword);
            VS_D:    wr_addr = addr_of(vd, wword);
            VS_SW:   wr_addr = addr_of(i_cmd.sw_vec[VW-1:0], wword);
            default: wr_addr = r_rd_addr;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_src)
            WR_BUF:  wr_data = r_buf[int'(wword) * WORD_BITS +: WORD_BITS] &
                               used_mask(wword, eff);
            WR_MASK: wr_data = r_rd_a & used_mask(r_rd_w, eff);
            WR_BIT: begin
                case (r_req.cmd)
                    CMD_SET:    wr_data = r_rd_a | bit_sel;
                    CMD_UNSET:  wr_data = r_rd_a & ~bit_sel;
                    CMD_TOGGLE: wr_data = r_rd_a ^ bit_sel;
                    default:    wr_data = r_rd_a;
                endcase
            end
            default: wr_data = '0;
        endcase
    end

    always_comb begin
        case (r_req.cmd)
            CMD_NOT:  op_word = ~r_rd_a;
            CMD_OR:   op_word = r_rd_a | r_rd_b;
            CMD_XOR:  op_word = r_rd_a ^ r_rd_b;
            CMD_AND:  op_word = r_rd_a & r_rd_b;
            CMD_DIFF: op_word = r_rd_a & ~r_rd_b;
            default:  op_word = r_rd_a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_a    <= r_mem[addr_a];
            r_rd_b    <= r_mem[addr_b];
            r_rd_addr <= addr_a;
            r_rd_w    <= wword;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 9'd256;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_req  <= i_req;
            r_pc   <= '0;
            r_all  <= 1'b1;
            r_flag <= 1'b0;
        end
        if (i_cmd.acc_en) begin
            case (r_req.cmd)
                CMD_COUNT: r_pc <= r_pc + PCW'($countones(r_rd_a));
                CMD_EMPTY: r_all <= r_all & (r_rd_a == '0);
                CMD_FULL:  r_all <= r_all & (r_rd_a == used_mask(r_rd_w, eff));
                CMD_EQUAL: r_all <= r_all & (r_rd_a == r_rd_b);
                default:   r_buf[int'(r_rd_w) * WORD_BITS +: WORD_BITS] <= op_word;
            endcase
        end else if (i_cmd.sh_en) begin
            if (r_req.shift_count >= eff) begin
                r_buf <= '0;
            end else if (r_req.cmd == CMD_LSHIFT) begin
                r_buf <= r_buf << r_req.shift_count;
            end else begin
                r_buf <= r_buf >> r_req.shift_count;
            end
        end
        if (i_cmd.bit_en) begin
            r_flag <= r_rd_a[bpos];
        end
        if (i_cmd.out_ld) begin
            r_rsp.flag      <= ((r_req.cmd == CMD_TEST) && r_flag) ||
                               ((r_req.cmd >= CMD_EMPTY) && (r_req.cmd <= CMD_EQUAL) && r_all);
            r_rsp.pop_count <= (r_req.cmd == CMD_COUNT) ? 9'(r_pc) : 9'd0;
            r_rsp.status    <= cmd_bit && o_stat.idx_bad;
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

/* hdl/bve_checker.sv */
`default_nettype none

module bve_checker
    import bve_pkg::*;
(
    input wire  i_clk,
    input wire  i_rst_n,
    input wire  i_req_valid,
    input wire  o_req_ready,
    input wire  o_rsp_valid,
    input wire  i_rsp_ready,
    input t_rsp o_rsp
);

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request accepted on back-to-back cycles");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_ready) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("stalled response changed");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status) |-> (!o_rsp.flag && o_rsp.pop_count == 9'd0))
        else $error("error status with nonzero result");

    a_count_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.pop_count != 9'd0) |-> !o_rsp.flag)
        else $error("count response with flag set");

endmodule

bind bit_vector_engine bve_checker u_bve_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);

`default_nettype wire
